>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL modules of the I2C slave byte engine.
// Needs nothing else; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property whose consequence must hold in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/i2cs_pkg.sv
// Types, codes and default sizes of the I2C slave byte engine.
// Used by the top level, the front end and the back end; depends on nothing.
package i2cs_pkg;

    localparam int RX_DEPTH_DEF = 64;
    localparam int TX_DEPTH_DEF = 32;
    localparam int RX_LEN_W     = 7;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_SHIFT = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_ENQ   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CTR_NONE   = 2'd0,
        CTR_LOAD0  = 2'd1,
        CTR_LOAD14 = 2'd2,
        CTR_READY  = 2'd3
    } t_ctr;

    typedef enum logic [1:0] {
        SDA_KEEP    = 2'd0,
        SDA_DRIVE   = 2'd1,
        SDA_RELEASE = 2'd2
    } t_sda;

    // Encoded state as seen on the result port.
    typedef enum logic [2:0] {
        SC_IDLE      = 3'd0,
        SC_ADDRESS   = 3'd1,
        SC_READ_ACK  = 3'd2,
        SC_WRITE_ACK = 3'd3,
        SC_SEND      = 3'd4,
        SC_RECEIVE   = 3'd5,
        SC_AWAIT_ACK = 3'd6
    } t_state_code;

    // Protocol state machine, one-hot.
    typedef enum logic [6:0] {
        BS_IDLE      = 7'b0000001,
        BS_ADDRESS   = 7'b0000010,
        BS_READ_ACK  = 7'b0000100,
        BS_WRITE_ACK = 7'b0001000,
        BS_SEND      = 7'b0010000,
        BS_RECEIVE   = 7'b0100000,
        BS_AWAIT_ACK = 7'b1000000
    } t_bus_state;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [2:0]          state_now;
        logic [1:0]          counter_action;
        logic [1:0]          sda_action;
        logic                tx_load;
        logic [7:0]          tx_byte;
        logic                rx_valid;
        logic [7:0]          rx_byte;
        logic [RX_LEN_W-1:0] rx_length;
        logic                enqueue_ok;
        logic                last;
    } t_out_item;

    // Classified request handed from the front to the back.
    typedef struct packed {
        t_req       op;
        logic [7:0] data;
        logic       addr_match;
    } t_cmd;

    function automatic t_state_code bus_code(input t_bus_state s);
        case (s)
            BS_IDLE:      bus_code = SC_IDLE;
            BS_ADDRESS:   bus_code = SC_ADDRESS;
            BS_READ_ACK:  bus_code = SC_READ_ACK;
            BS_WRITE_ACK: bus_code = SC_WRITE_ACK;
            BS_SEND:      bus_code = SC_SEND;
            BS_RECEIVE:   bus_code = SC_RECEIVE;
            BS_AWAIT_ACK: bus_code = SC_AWAIT_ACK;
            default:      bus_code = SC_IDLE;
        endcase
    endfunction

endpackage

>>> hw/rtl/i2c_slave_byte_engine.sv
// I2C slave byte engine, top level.
// Channels: requests enter on push/full (accepted when push is high and full is low);
// results leave on empty/pop (the oldest result is shown while empty is low and
// is taken when pop is high). The slave address is written on i_cfg_valid; the
// port is always ready and is meant to be written while the block is quiet.
// Each request (start, shift complete, stop, enqueue) gives one result, except a
// stop during a write, which gives one result per received byte, the last one
// carrying the ready actions; every run ends with last set.
// A request passes through the command queue, the back end's fetch (C_IDLE) and
// execute (C_EXEC) states and the output queue before its first result can be popped.
// The back end fetches the command and reads the transmit ring in C_IDLE and
// executes in C_EXEC, so it takes no new request until the last one is done.
// A stop delivery reads each byte from the receive store (a registered read, in
// C_DRD) and pushes it in C_DWR.
// Reset: the state machine goes idle, counts and ring pointers clear; the stores
// need no clearing. When the result side stalls, the output queue fills, the
// back end holds its work, the two-entry command queue fills and full rises.
// Depends on i2cs_pkg, i2cs_front, i2cs_fifo and i2cs_back.
module i2c_slave_byte_engine import i2cs_pkg::*; #(
    parameter int RX_DEPTH = RX_DEPTH_DEF,
    parameter int TX_DEPTH = TX_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  t_in_item   i_in,
    output t_out_item  o_out,
    output logic       empty,
    input  logic       pop,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data
);

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_out_item);

    logic             cmd_push;
    t_cmd             cmd_in;
    logic [CMD_W-1:0] cmd_q;
    logic             cmd_empty;
    logic             cmd_pop;
    logic             res_push;
    t_out_item        res_in;
    logic             res_full;
    logic [RES_W-1:0] res_q;

    i2cs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    i2cs_fifo #(
        .WIDTH (CMD_W)
    ) u_cmd_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (cmd_push),
        .i_wr_data (cmd_in),
        .o_full    (full),
        .i_rd_en   (cmd_pop),
        .o_rd_data (cmd_q),
        .o_empty   (cmd_empty)
    );

    i2cs_back #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_avail (!cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (t_cmd'(cmd_q)),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    i2cs_fifo #(
        .WIDTH (RES_W)
    ) u_res_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (res_push),
        .i_wr_data (res_in),
        .o_full    (res_full),
        .i_rd_en   (pop),
        .o_rd_data (res_q),
        .o_empty   (empty)
    );

    assign o_out = t_out_item'(res_q);

endmodule

>>> hw/rtl/i2cs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the receive store and the transmit ring.
module i2cs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/i2cs_fifo.sv
// Two-entry register queue used between the front and the back and at the output.
// Stand-alone; the payload is a plain bit vector of WIDTH bits.
module i2cs_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, n_wp;
    logic             r_rp, n_rp;
    logic [1:0]       r_cnt, n_cnt;
    logic             wr_go;
    logic             rd_go;

    assign o_full    = (r_cnt == 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign wr_go     = i_wr_en && !o_full;
    assign rd_go     = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rp];

    always_comb begin
        n_wp  = wr_go ? !r_wp : r_wp;
        n_rp  = rd_go ? !r_rp : r_rp;
        n_cnt = r_cnt;
        if (wr_go && !rd_go) begin
            n_cnt = r_cnt + 2'd1;
        end else if (rd_go && !wr_go) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

endmodule

>>> hw/rtl/i2cs_front.sv
// Front end: holds the slave address register and classifies each request.
// Depends on i2cs_pkg for the request and command types.
module i2cs_front import i2cs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_in_item   i_in,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);

    logic [6:0] r_own_addr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= 7'd0;
        end else if (i_cfg_valid) begin
            r_own_addr <= i_cfg_data;
        end
    end

    // The address compare is done here so the back only sees a match flag.
    always_comb begin
        o_cmd.op         = t_req'(i_in.req_type);
        o_cmd.data       = i_in.data_byte;
        o_cmd.addr_match = (i_in.data_byte[7:1] == r_own_addr);
    end

    assign o_cmd_push = i_push;

endmodule

>>> hw/rtl/i2cs_back.sv
// Back end: protocol state machine, receive store, transmit ring and result build.
// Depends on i2cs_pkg, i2cs_ram and assert_macros.svh.
`include "assert_macros.svh"

module i2cs_back import i2cs_pkg::*; #(
    parameter int RX_DEPTH = RX_DEPTH_DEF,
    parameter int TX_DEPTH = TX_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_avail,
    output logic      o_cmd_pop,
    input  t_cmd      i_cmd,
    input  logic      i_res_full,
    output logic      o_res_push,
    output t_out_item o_res
);

    localparam int RAW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int CW  = $clog2(RX_DEPTH + 1);
    localparam int TAW = $clog2(TX_DEPTH);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_EXEC = 4'b0010,
        C_DRD  = 4'b0100,
        C_DWR  = 4'b1000
    } t_ctl;

    t_ctl           r_ctl, n_ctl;
    t_cmd           r_cmd, n_cmd;
    t_bus_state     r_bus, n_bus;
    logic [CW-1:0]  r_rx_count, n_rx_count;
    logic [CW-1:0]  r_k, n_k;
    logic [TAW-1:0] r_tx_head, n_tx_head;
    logic [TAW-1:0] r_tx_tail, n_tx_tail;
    logic           r_tx_full, n_tx_full;

    logic           rx_we;
    logic           tx_we;
    logic [7:0]     rx_rdata;
    logic [7:0]     tx_rdata;
    logic           ring_busy;
    logic [7:0]     ld_byte;
    logic [TAW-1:0] head_inc;
    logic [TAW-1:0] tail_inc;
    logic           last_byte;

    i2cs_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH),
        .AW    (RAW)
    ) u_rx_store (
        .i_clk     (i_clk),
        .i_wr_en   (rx_we),
        .i_wr_addr (r_rx_count[RAW-1:0]),
        .i_wr_data (r_cmd.data),
        .i_rd_en   (r_ctl == C_DRD),
        .i_rd_addr (r_k[RAW-1:0]),
        .o_rd_data (rx_rdata)
    );

    // The ring is read at the head every cycle; the head only moves in C_EXEC,
    // which always follows a C_IDLE cycle, so the data is current there.
    i2cs_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH),
        .AW    (TAW)
    ) u_tx_ring (
        .i_clk     (i_clk),
        .i_wr_en   (tx_we),
        .i_wr_addr (r_tx_tail),
        .i_wr_data (r_cmd.data),
        .i_rd_en   (1'b1),
        .i_rd_addr (r_tx_head),
        .o_rd_data (tx_rdata)
    );

    assign ring_busy = (r_tx_head != r_tx_tail) || r_tx_full;
    assign ld_byte   = ring_busy ? tx_rdata : 8'hFF;
    assign head_inc  = (r_tx_head == TAW'(TX_DEPTH - 1)) ? '0 : r_tx_head + TAW'(1);
    assign tail_inc  = (r_tx_tail == TAW'(TX_DEPTH - 1)) ? '0 : r_tx_tail + TAW'(1);
    assign last_byte = ((r_k + CW'(1)) == r_rx_count);

    always_comb begin
        n_ctl      = r_ctl;
        n_cmd      = r_cmd;
        n_bus      = r_bus;
        n_rx_count = r_rx_count;
        n_k        = r_k;
        n_tx_head  = r_tx_head;
        n_tx_tail  = r_tx_tail;
        n_tx_full  = r_tx_full;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        rx_we      = 1'b0;
        tx_we      = 1'b0;
        o_res      = '0;
        o_res.last = 1'b1;

        case (r_ctl)
            C_IDLE: begin
                if (i_cmd_avail) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_ctl     = C_EXEC;
                end
            end
            C_EXEC: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_ctl      = C_IDLE;
                    case (r_cmd.op)
                        REQ_START: begin
                            o_res.counter_action = CTR_LOAD0;
                            n_bus                = BS_ADDRESS;
                            n_rx_count           = '0;
                        end
                        REQ_SHIFT: begin
                            case (r_bus)
                                BS_ADDRESS: begin
                                    if (r_cmd.addr_match) begin
                                        o_res.counter_action = CTR_LOAD14;
                                        o_res.sda_action     = SDA_DRIVE;
                                        o_res.tx_load        = 1'b1;
                                        n_bus = r_cmd.data[0] ? BS_READ_ACK : BS_WRITE_ACK;
                                    end else begin
                                        o_res.counter_action = CTR_READY;
                                        o_res.sda_action     = SDA_RELEASE;
                                        n_bus                = BS_IDLE;
                                    end
                                end
                                BS_WRITE_ACK: begin
                                    o_res.sda_action = SDA_RELEASE;
                                    n_bus            = BS_RECEIVE;
                                end
                                BS_RECEIVE: begin
                                    o_res.counter_action = CTR_LOAD14;
                                    o_res.sda_action     = SDA_DRIVE;
                                    o_res.tx_load        = 1'b1;
                                    n_bus                = BS_WRITE_ACK;
                                    // Bytes past the end of the store are acknowledged
                                    // but not kept.
                                    if (r_rx_count < CW'(RX_DEPTH)) begin
                                        rx_we      = 1'b1;
                                        n_rx_count = r_rx_count + CW'(1);
                                    end
                                end
                                BS_READ_ACK: begin
                                    o_res.counter_action = CTR_LOAD0;
                                    o_res.sda_action     = SDA_DRIVE;
                                    o_res.tx_load        = 1'b1;
                                    o_res.tx_byte        = ld_byte;
                                    n_bus                = BS_SEND;
                                    if (ring_busy) begin
                                        n_tx_head = head_inc;
                                        n_tx_full = 1'b0;
                                    end
                                end
                                BS_SEND: begin
                                    o_res.counter_action = CTR_LOAD14;
                                    o_res.sda_action     = SDA_RELEASE;
                                    n_bus                = BS_AWAIT_ACK;
                                end
                                BS_AWAIT_ACK: begin
                                    if (r_cmd.data[0]) begin
                                        o_res.counter_action = CTR_READY;
                                        o_res.sda_action     = SDA_RELEASE;
                                        n_bus                = BS_IDLE;
                                    end else begin
                                        o_res.counter_action = CTR_LOAD0;
                                        o_res.sda_action     = SDA_DRIVE;
                                        o_res.tx_load        = 1'b1;
                                        o_res.tx_byte        = ld_byte;
                                        n_bus                = BS_SEND;
                                        if (ring_busy) begin
                                            n_tx_head = head_inc;
                                            n_tx_full = 1'b0;
                                        end
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        REQ_STOP: begin
                            if (r_bus == BS_RECEIVE) begin
                                if (r_rx_count != '0) begin
                                    // Hand the stored run out one byte at a time.
                                    o_res_push = 1'b0;
                                    n_k        = '0;
                                    n_ctl      = C_DRD;
                                end else begin
                                    o_res.counter_action = CTR_READY;
                                    o_res.sda_action     = SDA_RELEASE;
                                    n_bus                = BS_IDLE;
                                end
                            end
                        end
                        REQ_ENQ: begin
                            if (!r_tx_full) begin
                                tx_we            = 1'b1;
                                n_tx_tail        = tail_inc;
                                n_tx_full        = (tail_inc == r_tx_head);
                                o_res.enqueue_ok = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    o_res.state_now = bus_code(n_bus);
                end
            end
            C_DRD: begin
                n_ctl = C_DWR;
            end
            C_DWR: begin
                if (!i_res_full) begin
                    o_res_push      = 1'b1;
                    o_res.state_now = SC_IDLE;
                    o_res.rx_valid  = 1'b1;
                    o_res.rx_byte   = rx_rdata;
                    o_res.rx_length = RX_LEN_W'(r_rx_count);
                    o_res.last      = last_byte;
                    if (last_byte) begin
                        o_res.counter_action = CTR_READY;
                        o_res.sda_action     = SDA_RELEASE;
                        n_bus                = BS_IDLE;
                        n_ctl                = C_IDLE;
                    end else begin
                        n_k   = r_k + CW'(1);
                        n_ctl = C_DRD;
                    end
                end
            end
            default: begin
                n_ctl = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl      <= C_IDLE;
            r_bus      <= BS_IDLE;
            r_rx_count <= '0;
            r_k        <= '0;
            r_tx_head  <= '0;
            r_tx_tail  <= '0;
            r_tx_full  <= 1'b0;
        end else begin
            r_ctl      <= n_ctl;
            r_bus      <= n_bus;
            r_rx_count <= n_rx_count;
            r_k        <= n_k;
            r_tx_head  <= n_tx_head;
            r_tx_tail  <= n_tx_tail;
            r_tx_full  <= n_tx_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    `ASSERT_CLK(a_full_ptrs, i_clk, i_rst_n, r_tx_full |-> (r_tx_head == r_tx_tail), "ring full but head and tail differ")
    `ASSERT_CLK(a_rx_bound, i_clk, i_rst_n, r_rx_count <= CW'(RX_DEPTH), "receive count beyond store depth")
    `ASSERT_CLK(a_push_src, i_clk, i_rst_n, o_res_push |-> (r_ctl == C_EXEC || r_ctl == C_DWR), "result pushed outside an emitting state")
    `ASSERT_NEXT(a_deliver_end, i_clk, i_rst_n, (r_ctl == C_DWR) && !i_res_full && last_byte, (r_ctl == C_IDLE) && (r_bus == BS_IDLE), "delivery did not end in idle")

endmodule

>>> sim/tb_i2c_slave_byte_engine.sv
// Self-checking testbench for the I2C slave byte engine: directed bus sequences, then
// random write, read, enqueue and noise traffic, checked against a local predictor.
// Depends on i2cs_pkg and the i2c_slave_byte_engine top level.
module tb_i2c_slave_byte_engine import i2cs_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TX_AW       = $clog2(TX_DEPTH_DEF);

    typedef struct {
        t_in_item  req;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      push        = 1'b0;
    logic      full;
    t_in_item  req_bus     = '0;
    t_out_item res_bus;
    logic      empty;
    logic      pop         = 1'b0;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [6:0] i_cfg_data = '0;

    // Predictor state.
    logic [6:0]       own_addr = '0;
    t_state_code      bus = SC_IDLE;
    int               rx_cnt = 0;
    logic [7:0]       rx_mem[RX_DEPTH_DEF];
    logic [7:0]       tx_mem[TX_DEPTH_DEF];
    logic [TX_AW-1:0] tx_rd = '0;
    logic [TX_AW-1:0] tx_wr = '0;
    logic             tx_full_f = 1'b0;

    t_out_item pending_results[$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        cycle_cnt = 0;
    int        pop_stall = 0;
    bit        push_gaps = 1'b0;
    bit        pop_gaps = 1'b0;
    bit        hold_pop = 1'b0;
    t_dir_row  dir_tab[$];

    i2c_slave_byte_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (req_bus),
        .o_out       (res_bus),
        .empty       (empty),
        .pop         (pop),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_out_item outcome(input t_state_code st, input t_ctr ca,
                                          input t_sda sa, input logic ld,
                                          input logic [7:0] tb, input logic ok);
        t_out_item r;
        r = '0;
        r.state_now      = st;
        r.counter_action = ca;
        r.sda_action     = sa;
        r.tx_load        = ld;
        r.tx_byte        = tb;
        r.enqueue_ok     = ok;
        r.last           = 1'b1;
        return r;
    endfunction

    // Next byte to send: the oldest queued byte, or all ones when the ring is empty.
    function automatic logic [7:0] pull_tx_byte();
        logic [7:0] b;
        b = 8'hFF;
        if (tx_rd != tx_wr || tx_full_f) begin
            b = tx_mem[tx_rd];
            tx_rd = tx_rd + 1'b1;
            tx_full_f = 1'b0;
        end
        return b;
    endfunction

    // Appends the results of one request to pending_results; returns their number.
    function automatic int predict_bus_event(input t_in_item it);
        t_out_item r;
        t_out_item byte_res;
        int n;
        r = '0;
        n = 1;
        case (it.req_type)
            REQ_START: begin
                r.counter_action = CTR_LOAD0;
                bus = SC_ADDRESS;
                rx_cnt = 0;
            end
            REQ_SHIFT: begin
                case (bus)
                    SC_ADDRESS: begin
                        if (it.data_byte[7:1] == own_addr) begin
                            r.counter_action = CTR_LOAD14;
                            r.sda_action = SDA_DRIVE;
                            r.tx_load = 1'b1;
                            bus = it.data_byte[0] ? SC_READ_ACK : SC_WRITE_ACK;
                        end else begin
                            r.counter_action = CTR_READY;
                            r.sda_action = SDA_RELEASE;
                            bus = SC_IDLE;
                        end
                    end
                    SC_WRITE_ACK: begin
                        r.sda_action = SDA_RELEASE;
                        bus = SC_RECEIVE;
                    end
                    SC_RECEIVE: begin
                        r.counter_action = CTR_LOAD14;
                        r.sda_action = SDA_DRIVE;
                        r.tx_load = 1'b1;
                        bus = SC_WRITE_ACK;
                        // Once the store is full, bytes are still acknowledged.
                        if (rx_cnt < RX_DEPTH_DEF) begin
                            rx_mem[rx_cnt] = it.data_byte;
                            rx_cnt++;
                        end
                    end
                    SC_READ_ACK, SC_AWAIT_ACK: begin
                        if (bus == SC_AWAIT_ACK && it.data_byte[0]) begin
                            r.counter_action = CTR_READY;
                            r.sda_action = SDA_RELEASE;
                            bus = SC_IDLE;
                        end else begin
                            r.counter_action = CTR_LOAD0;
                            r.sda_action = SDA_DRIVE;
                            r.tx_load = 1'b1;
                            r.tx_byte = pull_tx_byte();
                            bus = SC_SEND;
                        end
                    end
                    SC_SEND: begin
                        r.counter_action = CTR_LOAD14;
                        r.sda_action = SDA_RELEASE;
                        bus = SC_AWAIT_ACK;
                    end
                    default: begin
                    end
                endcase
            end
            REQ_STOP: begin
                if (bus == SC_RECEIVE) begin
                    bus = SC_IDLE;
                    for (int k = 0; k + 1 < rx_cnt; k++) begin
                        byte_res = '0;
                        byte_res.state_now = SC_IDLE;
                        byte_res.rx_valid = 1'b1;
                        byte_res.rx_byte = rx_mem[k];
                        byte_res.rx_length = RX_LEN_W'(rx_cnt);
                        pending_results.push_back(byte_res);
                    end
                    if (rx_cnt > 0) begin
                        r.rx_valid = 1'b1;
                        r.rx_byte = rx_mem[rx_cnt - 1];
                        r.rx_length = RX_LEN_W'(rx_cnt);
                        n = rx_cnt;
                    end
                    r.counter_action = CTR_READY;
                    r.sda_action = SDA_RELEASE;
                end
            end
            default: begin
                if (!tx_full_f) begin
                    tx_mem[tx_wr] = it.data_byte;
                    tx_wr = tx_wr + 1'b1;
                    if (tx_wr == tx_rd)
                        tx_full_f = 1'b1;
                    r.enqueue_ok = 1'b1;
                end
            end
        endcase
        r.state_now = bus;
        r.last = 1'b1;
        pending_results.push_back(r);
        return n;
    endfunction

    task automatic flag_mismatch(input string what, input t_out_item want,
                                 input t_out_item got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch (%s): expected %h, got %h", $time, what, want, got);
    endtask

    // Offers one request; its results are predicted at the edge that accepts it.
    task automatic issue_request(input t_in_item it, input bit typed, input t_out_item want);
        int gap;
        int n;
        if (push_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        req_bus <= it;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        n = predict_bus_event(it);
        if (typed) begin
            repeat (n) void'(pending_results.pop_back());
            pending_results.push_back(want);
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic push_req(input logic [1:0] op, input logic [7:0] d, input logic eom);
        t_in_item it;
        it.req_type = op;
        it.data_byte = d;
        it.end_of_message = eom;
        issue_request(it, 1'b0, '0);
    endtask

    task automatic drain_and_set_address(input logic [6:0] addr);
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= addr;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        own_addr = addr;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One bus transaction or burst of random content, mostly well formed.
    task automatic random_transfer();
        int pick;
        int nb;
        logic [6:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            nb = ($urandom_range(0, 12) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 6);
            a = ($urandom_range(0, 9) == 0) ? 7'($urandom) : own_addr;
            push_req(REQ_START, 8'($urandom), 1'($urandom));
            push_req(REQ_SHIFT, {a, 1'b0}, 1'($urandom));
            // The address acknowledge bit clocks out before the first data byte.
            push_req(REQ_SHIFT, 8'($urandom), 1'($urandom));
            for (int k = 0; k < nb; k++) begin
                push_req(REQ_SHIFT, 8'($urandom), 1'($urandom));
                push_req(REQ_SHIFT, 8'($urandom), 1'($urandom));
            end
            // A stray shift leaves the engine in write ack, so the stop delivers nothing.
            if ($urandom_range(0, 9) == 0)
                push_req(REQ_SHIFT, 8'($urandom), 1'($urandom));
            push_req(REQ_STOP, 8'($urandom), 1'($urandom));
        end else if (pick < 70) begin
            nb = $urandom_range(0, 6);
            for (int k = 0; k < nb; k++)
                push_req(REQ_ENQ, 8'($urandom), k == nb - 1);
            nb = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 8);
            push_req(REQ_START, 8'($urandom), 1'($urandom));
            push_req(REQ_SHIFT, {own_addr, 1'b1}, 1'($urandom));
            push_req(REQ_SHIFT, 8'($urandom), 1'($urandom));
            for (int k = 0; k < nb; k++) begin
                push_req(REQ_SHIFT, 8'($urandom), 1'($urandom));
                push_req(REQ_SHIFT, {7'($urandom), 1'b0}, 1'($urandom));
            end
            push_req(REQ_SHIFT, 8'($urandom), 1'($urandom));
            push_req(REQ_SHIFT, {7'($urandom), 1'b1}, 1'($urandom));
            push_req(REQ_STOP, 8'($urandom), 1'($urandom));
        end else if (pick < 85) begin
            nb = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
            for (int k = 0; k < nb; k++)
                push_req(REQ_ENQ, 8'($urandom), k == nb - 1);
        end else begin
            nb = $urandom_range(1, 4);
            for (int k = 0; k < nb; k++)
                push_req(2'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    always @(negedge i_clk) begin
        if (pop_stall != 0) begin
            pop_stall = pop_stall - 1;
            pop <= 1'b0;
        end else if (pop_gaps && $urandom_range(0, 7) == 0) begin
            pop_stall = $urandom_range(0, 16);
            pop <= 1'b0;
        end else begin
            pop <= !hold_pop;
        end
    end

    // Long receiver hold-off so that the engine backs up and refuses requests.
    initial begin
        wait (items_sent >= 150);
        @(negedge i_clk);
        hold_pop = 1'b1;
        repeat (400) @(negedge i_clk);
        hold_pop = 1'b0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        string diff;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("no result pending", '0, res_bus);
            end else begin
                want = pending_results.pop_front();
                diff = "";
                if (res_bus.state_now !== want.state_now)           diff = {diff, " state_now"};
                if (res_bus.counter_action !== want.counter_action) diff = {diff, " counter"};
                if (res_bus.sda_action !== want.sda_action)         diff = {diff, " sda"};
                if (res_bus.tx_load !== want.tx_load)               diff = {diff, " tx_load"};
                if (res_bus.tx_byte !== want.tx_byte)               diff = {diff, " tx_byte"};
                if (res_bus.rx_valid !== want.rx_valid)             diff = {diff, " rx_valid"};
                if (res_bus.rx_byte !== want.rx_byte)               diff = {diff, " rx_byte"};
                if (res_bus.rx_length !== want.rx_length)           diff = {diff, " rx_length"};
                if (res_bus.enqueue_ok !== want.enqueue_ok)         diff = {diff, " enqueue_ok"};
                if (res_bus.last !== want.last)                     diff = {diff, " last"};
                if (diff != "")
                    flag_mismatch({"field", diff}, want, res_bus);
            end
        end
    end

    initial begin
        logic [6:0] phase_addr[4];
        dir_tab = '{
            '{'{REQ_SHIFT, 8'h00, 1'b0}, 1'b1,
              outcome(SC_IDLE, CTR_NONE, SDA_KEEP, 1'b0, 8'h00, 1'b0)},
            '{'{REQ_STOP, 8'h5A, 1'b1}, 1'b1,
              outcome(SC_IDLE, CTR_NONE, SDA_KEEP, 1'b0, 8'h00, 1'b0)},
            '{'{REQ_ENQ, 8'h00, 1'b0}, 1'b1,
              outcome(SC_IDLE, CTR_NONE, SDA_KEEP, 1'b0, 8'h00, 1'b1)},
            '{'{REQ_ENQ, 8'hFF, 1'b1}, 1'b1,
              outcome(SC_IDLE, CTR_NONE, SDA_KEEP, 1'b0, 8'h00, 1'b1)},
            '{'{REQ_START, 8'h00, 1'b0}, 1'b1,
              outcome(SC_ADDRESS, CTR_LOAD0, SDA_KEEP, 1'b0, 8'h00, 1'b0)},
            '{'{REQ_SHIFT, 8'h20, 1'b0}, 1'b1,
              outcome(SC_IDLE, CTR_READY, SDA_RELEASE, 1'b0, 8'h00, 1'b0)},
            '{'{REQ_START, 8'hFF, 1'b1}, 1'b1,
              outcome(SC_ADDRESS, CTR_LOAD0, SDA_KEEP, 1'b0, 8'h00, 1'b0)},
            '{'{REQ_SHIFT, 8'hA0, 1'b0}, 1'b1,
              outcome(SC_WRITE_ACK, CTR_LOAD14, SDA_DRIVE, 1'b1, 8'h00, 1'b0)},
            '{'{REQ_SHIFT, 8'h00, 1'b0}, 1'b0, '0},
            '{'{REQ_SHIFT, 8'hFF, 1'b1}, 1'b0, '0},
            '{'{REQ_SHIFT, 8'h00, 1'b0}, 1'b0, '0},
            '{'{REQ_SHIFT, 8'h00, 1'b0}, 1'b0, '0},
            '{'{REQ_SHIFT, 8'h00, 1'b0}, 1'b0, '0},
            '{'{REQ_STOP, 8'h00, 1'b0}, 1'b0, '0},
            '{'{REQ_START, 8'h00, 1'b0}, 1'b0, '0},
            '{'{REQ_SHIFT, 8'hA0, 1'b1}, 1'b1,
              outcome(SC_WRITE_ACK, CTR_LOAD14, SDA_DRIVE, 1'b1, 8'h00, 1'b0)},
            '{'{REQ_SHIFT, 8'h00, 1'b0}, 1'b0, '0},
            '{'{REQ_STOP, 8'h00, 1'b0}, 1'b1,
              outcome(SC_IDLE, CTR_READY, SDA_RELEASE, 1'b0, 8'h00, 1'b0)},
            '{'{REQ_START, 8'h00, 1'b0}, 1'b0, '0},
            '{'{REQ_SHIFT, 8'hA1, 1'b0}, 1'b1,
              outcome(SC_READ_ACK, CTR_LOAD14, SDA_DRIVE, 1'b1, 8'h00, 1'b0)},
            '{'{REQ_SHIFT, 8'h00, 1'b0}, 1'b0, '0},
            '{'{REQ_SHIFT, 8'h00, 1'b0}, 1'b0, '0},
            '{'{REQ_SHIFT, 8'h00, 1'b0}, 1'b0, '0},
            '{'{REQ_SHIFT, 8'h00, 1'b0}, 1'b0, '0},
            '{'{REQ_SHIFT, 8'h00, 1'b0}, 1'b0, '0},
            '{'{REQ_SHIFT, 8'h00, 1'b0}, 1'b0, '0},
            '{'{REQ_SHIFT, 8'h01, 1'b1}, 1'b1,
              outcome(SC_IDLE, CTR_READY, SDA_RELEASE, 1'b0, 8'h00, 1'b0)},
            '{'{REQ_STOP, 8'hFF, 1'b0}, 1'b1,
              outcome(SC_IDLE, CTR_NONE, SDA_KEEP, 1'b0, 8'h00, 1'b0)}
        };
        phase_addr[0] = 7'h00;
        phase_addr[1] = 7'h7F;
        phase_addr[2] = 7'($urandom_range(1, 126));
        phase_addr[3] = 7'($urandom);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_gaps = 1'b1;
        pop_gaps = 1'b1;
        drain_and_set_address(7'h50);
        foreach (dir_tab[i])
            issue_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);

        for (int p = 0; p < 4; p++) begin
            drain_and_set_address(phase_addr[p]);
            // The receiver keeps idling one phase longer than the sender; the last has none.
            push_gaps = (p < 2);
            pop_gaps = (p < 3);
            while (items_sent < dir_tab.size() + (p + 1) * 112)
                random_transfer();
        end

        push <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (12) @(negedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
